@@ design/dhf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared types and register indexes for the depth hole fill core.
// ----------------------------------------------------------------------------
package dhf_pkg;

  localparam logic [1:0] REG_MIN_DEPTH = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // one classified request passed from front to back
  typedef struct packed {
    logic        query;   // 0 = store pixel, 1 = query
    logic        in_image;
    logic [9:0]  column;
    logic [8:0]  row;
    logic [15:0] depth_value;
  } dhf_req_t;

  typedef struct packed {
    logic [15:0] min_depth;
    logic [7:0]  radius;
    logic [12:0] width;
    logic [12:0] height;
  } dhf_cfg_t;

endpackage

@@ design/dhf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhf_front
// Accepts input requests, checks bounds and queues them for the back end.
// ----------------------------------------------------------------------------
module dhf_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [9:0]        in_column,
  input  logic [8:0]        in_row,
  input  logic [15:0]       in_depth,
  input  dhf_pkg::dhf_cfg_t cfg,
  output logic              req_valid,
  input  logic              req_ready,
  output dhf_pkg::dhf_req_t req
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  dhf_pkg::dhf_req_t queue [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;
  dhf_pkg::dhf_req_t incoming;

  assign in_ready  = (fill != (PW+1)'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign req_valid = (fill != '0);
  assign pop       = req_valid && req_ready;
  assign req       = queue[rd_ptr];

  always_comb begin
    incoming.query       = (in_op == dhf_pkg::OP_QUERY);
    incoming.in_image    = ({3'b0, in_column} < cfg.width) && ({4'b0, in_row} < cfg.height);
    incoming.column      = in_column;
    incoming.row         = in_row;
    incoming.depth_value = in_depth;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == (PW+1)'(QUEUE_DEPTH)) |-> !push) else $error("push into full queue");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 1'b1) else $error("fill count slip");
`endif

endmodule

@@ design/dhf_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhf_divider #(
  parameter int NW = 26,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [DW:0]   rem;
  logic [DW-1:0] div;
  logic [CW-1:0] cnt;
  logic [DW+1:0] trial;
  logic [DW:0]   rem_sh;

  assign rem_sh = {rem[DW-1:0], num_sh[NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        num_sh <= numer;
        div    <= denom;
        rem    <= '0;
        quot   <= '0;
        cnt    <= CW'(NW);
      end else if (busy) begin
        num_sh <= num_sh << 1;
        if (!trial[DW+1]) begin
          rem  <= trial[DW:0];
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/dhf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhf_back
// Holds the depth image; executes stores and window-mean queries.
// ----------------------------------------------------------------------------
module dhf_back #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  dhf_pkg::dhf_cfg_t cfg,
  input  logic              req_valid,
  output logic              req_ready,
  input  dhf_pkg::dhf_req_t req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_depth,
  output logic              out_filled
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int CNTW  = $clog2(WIN * WIN + 1);
  localparam int SUMW  = 16 + CNTW;

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_CHECK, S_WALK, S_DRAIN, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [9:0]  q_col;
  logic [8:0]  q_row;
  logic [13:0] x_lo, x_hi, y_hi, x, y;   // signed-free: offset by MAX_RADIUS
  logic        pend_valid;               // a read issued last cycle in window
  logic        pend_in;
  logic [SUMW-1:0] sum;
  logic [CNTW-1:0] cnt;
  logic        div_start, div_busy, div_done;
  logic [SUMW-1:0] div_q;
  logic [13:0] rad;
  logic        at_x_end, pt_in;

  assign rad = {6'b0, cfg.radius};
  // coordinates carried biased by MAX_RADIUS so they stay nonnegative
  assign pt_in = (x >= 14'(MAX_RADIUS)) && (x < 14'(MAX_RADIUS) + {1'b0, cfg.width})
              && (y >= 14'(MAX_RADIUS)) && (y < 14'(MAX_RADIUS) + {1'b0, cfg.height});
  assign at_x_end = (x == x_hi);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == S_IDLE && req_valid) begin
      rd_en   = req.query && req.in_image;
      rd_addr = AW'(32'(req.row) * 32'(MAX_WIDTH) + 32'(req.column));
    end else if (state == S_WALK) begin
      rd_en   = pt_in;
      rd_addr = AW'(32'(y - 14'(MAX_RADIUS)) * 32'(MAX_WIDTH)
                    + 32'(x - 14'(MAX_RADIUS)));
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid && !req.query && req.in_image) begin
      mem[AW'(32'(req.row) * 32'(MAX_WIDTH) + 32'(req.column))] <= req.depth_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign req_ready = (state == S_IDLE);
  assign div_start = (state == S_DRAIN) && !pend_valid;

  dhf_divider #(.NW(SUMW), .DW(CNTW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start && (cnt != '0)),
    .numer (sum),
    .denom (cnt),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid && req.query) begin
            q_col <= req.column;
            q_row <= req.row;
            if (req.in_image) begin
              state <= S_RAW;
            end else begin
              out_depth  <= '0;
              out_filled <= 1'b0;
              out_valid  <= 1'b1;
              state      <= S_OUT;
            end
          end
        end
        S_RAW: state <= S_CHECK;
        S_CHECK: begin
          if (rd_data < cfg.min_depth) begin
            x_lo  <= 14'(MAX_RADIUS) + {4'b0, q_col} - rad;
            x_hi  <= 14'(MAX_RADIUS) + {4'b0, q_col} + rad;
            y_hi  <= 14'(MAX_RADIUS) + {5'b0, q_row} + rad;
            x     <= 14'(MAX_RADIUS) + {4'b0, q_col} - rad;
            y     <= 14'(MAX_RADIUS) + {5'b0, q_row} - rad;
            sum   <= '0;
            cnt   <= '0;
            pend_valid <= 1'b0;
            state <= S_WALK;
          end else begin
            out_depth  <= rd_data;
            out_filled <= 1'b0;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_WALK: begin
          pend_valid <= 1'b1;
          pend_in    <= pt_in;
          if (at_x_end) begin
            x <= x_lo;
            y <= y + 1'b1;
            if (y == y_hi) state <= S_DRAIN;
          end else begin
            x <= x + 1'b1;
          end
        end
        S_DRAIN: begin
          pend_valid <= 1'b0;
          if (!pend_valid) begin
            if (cnt == '0) begin
              out_depth  <= '0;
              out_filled <= 1'b1;
              out_valid  <= 1'b1;
              state      <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_depth  <= div_q[15:0];
            out_filled <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // accumulate the pixel read in the previous cycle
      if (pend_valid && pend_in && rd_data != '0) begin
        sum <= sum + SUMW'(rd_data);
        cnt <= cnt + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_depth))
    else $error("result dropped while stalled");
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_OUT)) else $error("result flag out of step");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV) else $error("divider busy outside divide");
`endif

endmodule

@@ design/depth_hole_fill_window_mean_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_hole_fill_window_mean_core
// Depth image store with hole filling by neighborhood mean.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: operation[0], column[10:1], row[19:11], depth_value[35:20]
// m_axis  | out | tdata: depth_mm[15:0]; tuser: filled
// cfg     | in  | cfg_we, cfg_index, cfg_data
//
// A store is written from the idle state; a query with a good pixel passes
// through S_RAW and S_CHECK to S_OUT. A filled query walks (2R+1)^2 window
// cells, one per cycle, reading those inside the image, then runs a 26-step
// bit-serial divide (skipped if no nonzero neighbor); an output stall holds S_OUT.
// Reset clears control only; the pixel memory is undefined until written.
// A four-entry request queue lets input stay accepted while the back end works, until it is full.
// ----------------------------------------------------------------------------
module depth_hole_fill_window_mean_core #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int MAX_RADIUS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operation, column, row, depth_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // depth_mm
  output logic        m_axis_tuser,   // filled
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] min_depth;
  logic [3:0]  radius;
  logic [9:0]  width;
  logic [8:0]  height;
  dhf_pkg::dhf_cfg_t cfg;
  dhf_pkg::dhf_req_t req;
  logic req_valid, req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= 16'd100;
      radius    <= 4'd2;
      width     <= 10'd640;
      height    <= 9'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhf_pkg::REG_MIN_DEPTH: min_depth <= cfg_data;
        dhf_pkg::REG_RADIUS:    radius    <= cfg_data[3:0];
        dhf_pkg::REG_WIDTH:     width     <= cfg_data[9:0];
        dhf_pkg::REG_HEIGHT:    height    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // saturate the live settings to the built sizes; zero width or height reads as 1
  always_comb begin
    cfg.min_depth = min_depth;
    cfg.radius    = (32'(radius) > MAX_RADIUS) ? 8'(MAX_RADIUS) : 8'(radius);
    cfg.width     = (width == '0) ? 13'd1 :
                    (32'(width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(width);
    cfg.height    = (height == '0) ? 13'd1 :
                    (32'(height) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(height);
  end

  dhf_front #(.QUEUE_DEPTH(4)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tdata[0]),
    .in_column (s_axis_tdata[10:1]),
    .in_row    (s_axis_tdata[19:11]),
    .in_depth  (s_axis_tdata[35:20]),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  dhf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_depth  (m_axis_tdata),
    .out_filled (m_axis_tuser)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for depth_hole_fill_window_mean_core. Pixel writes and
// depth queries are streamed in under several register settings, with random
// gaps on both sides. A software copy of the depth image predicts each
// corrected depth and filled flag. Queries are only issued once every pixel
// they can touch has been written.
// ----------------------------------------------------------------------------
module tb;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;
  localparam int RAD_MAX = 15;

  typedef struct {
    logic [15:0] depth;
    logic        filled;
  } depth_result_t;

  class fill_scoreboard;
    logic [15:0]   pixels [IMG_W*IMG_H];
    logic [15:0]   min_depth;
    logic [3:0]    radius;
    logic [9:0]    width;
    logic [8:0]    height;
    depth_result_t pending_q[$];
    int            errors;

    function void reset_regs();
      min_depth = 16'd100;
      radius    = 4'd2;
      width     = 10'd640;
      height    = 9'd480;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        dhf_pkg::REG_MIN_DEPTH: min_depth = val;
        dhf_pkg::REG_RADIUS:    radius    = val[3:0];
        dhf_pkg::REG_WIDTH:     width     = val[9:0];
        dhf_pkg::REG_HEIGHT:    height    = val[8:0];
        default: ;
      endcase
    endfunction

    function int eff_w();
      return (width == 0) ? 1 : (width > IMG_W) ? IMG_W : width;
    endfunction

    function int eff_h();
      return (height == 0) ? 1 : (height > IMG_H) ? IMG_H : height;
    endfunction

    function int eff_r();
      return (radius > RAD_MAX) ? RAD_MAX : radius;
    endfunction

    function void note_request(logic op, int col, int row, logic [15:0] val);
      depth_result_t res;
      int            sum;
      int            cnt;
      int            x;
      int            y;
      logic [15:0]   raw;
      bit            in_image;
      in_image = (col < eff_w()) && (row < eff_h());
      if (op == dhf_pkg::OP_WRITE) begin
        if (in_image) pixels[row*IMG_W+col] = val;
        return;
      end
      res.depth  = 16'd0;
      res.filled = 1'b0;
      if (in_image) begin
        raw = pixels[row*IMG_W+col];
        if (raw < min_depth) begin
          sum = 0;
          cnt = 0;
          for (y = row - eff_r(); y <= row + eff_r(); y++) begin
            for (x = col - eff_r(); x <= col + eff_r(); x++) begin
              if (y < 0 || y >= eff_h() || x < 0 || x >= eff_w()) continue;
              if (pixels[y*IMG_W+x] == 0) continue;
              sum += pixels[y*IMG_W+x];
              cnt++;
            end
          end
          res.depth  = (cnt != 0) ? 16'(sum / cnt) : 16'd0;
          res.filled = 1'b1;
        end else begin
          res.depth = raw;
        end
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] depth, logic filled);
      depth_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result depth_mm=%0d filled=%0d", depth, filled);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (depth !== exp_r.depth) begin
        $error("depth_mm: expected %0d, got %0d", exp_r.depth, depth);
        errors++;
      end
      if (filled !== exp_r.filled) begin
        $error("filled: expected %0d, got %0d", exp_r.filled, filled);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // operation, column, row, depth_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // depth_mm
  logic        m_axis_tuser;        // filled
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = dhf_pkg::REG_MIN_DEPTH;
  logic [15:0] cfg_data = '0;

  fill_scoreboard sb = new();
  bit  written [IMG_W*IMG_H];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  depth_hole_fill_window_mean_core u_dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #100ms;
    $display("depth_hole_fill_window_mean_core regression: fail");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_request(logic op, int col, int row, logic [15:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, val, row[8:0], col[9:0], op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, col, row, val);
    if (op == dhf_pkg::OP_WRITE && col < sb.eff_w() && row < sb.eff_h())
      written[row*IMG_W+col] = 1'b1;
  endtask

  // wait out the queue, then the longest window walk
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  // first unwritten pixel that a query at (col,row) could read
  function automatic bit find_hole(int col, int row, output int hc, output int hr);
    int x;
    int y;
    if (col >= sb.eff_w() || row >= sb.eff_h()) return 0;
    for (y = row - sb.eff_r(); y <= row + sb.eff_r(); y++)
      for (x = col - sb.eff_r(); x <= col + sb.eff_r(); x++) begin
        if (y < 0 || y >= sb.eff_h() || x < 0 || x >= sb.eff_w()) continue;
        if (!written[y*IMG_W+x]) begin
          hc = x;
          hr = y;
          return 1;
        end
      end
    return 0;
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'($urandom_range(150));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(int min_d, int rad, int w, int h, int c0, int r0, int zw, int zh,
                           int n, int mode);
    int   i;
    int   col;
    int   row;
    int   hc;
    int   hr;
    logic op;
    write_reg(dhf_pkg::REG_MIN_DEPTH, 16'(min_d));
    write_reg(dhf_pkg::REG_RADIUS, 16'(rad));
    write_reg(dhf_pkg::REG_WIDTH, 16'(w));
    write_reg(dhf_pkg::REG_HEIGHT, 16'(h));
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
    for (i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if ($urandom_range(99) < 8) begin
        op  = 1'($urandom_range(1));
        col = $urandom_range(1023);
        row = $urandom_range(511);
      end else begin
        op  = ($urandom_range(99) < 62) ? dhf_pkg::OP_QUERY : dhf_pkg::OP_WRITE;
        col = c0 + $urandom_range(zw - 1);
        row = r0 + $urandom_range(zh - 1);
      end
      if (op == dhf_pkg::OP_QUERY && find_hole(col, row, hc, hr))
        send_request(dhf_pkg::OP_WRITE, hc, hr, pick_depth());
      else
        send_request(op, col, row,
                     (op == dhf_pkg::OP_QUERY) ? 16'($urandom) : pick_depth());
    end
    drain();
  endtask

  initial begin
    int c0;
    int r0;
    sb.reset_regs();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // small 3x2 image under reset settings
    write_reg(dhf_pkg::REG_WIDTH, 16'd3);
    write_reg(dhf_pkg::REG_HEIGHT, 16'd2);
    send_request(dhf_pkg::OP_WRITE, 0, 0, 16'd0);
    send_request(dhf_pkg::OP_WRITE, 1, 0, 16'd50);
    send_request(dhf_pkg::OP_WRITE, 2, 0, 16'hFFFF);
    send_request(dhf_pkg::OP_WRITE, 0, 1, 16'd200);
    send_request(dhf_pkg::OP_WRITE, 1, 1, 16'd0);
    send_request(dhf_pkg::OP_WRITE, 2, 1, 16'd1);
    send_request(dhf_pkg::OP_WRITE, 1023, 511, 16'hFFFF);  // outside, dropped
    send_request(dhf_pkg::OP_WRITE, 5, 0, 16'd7);          // outside, dropped
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) send_request(dhf_pkg::OP_QUERY, c, r, 16'hFFFF);
    send_request(dhf_pkg::OP_QUERY, 3, 0, 16'd0);
    send_request(dhf_pkg::OP_QUERY, 0, 2, 16'd0);
    send_request(dhf_pkg::OP_QUERY, 1023, 511, 16'd0);
    drain();

    run_phase(65535, 15, 12, 8, 0, 0, 12, 8, 250, 0);
    run_phase(65535, 0, 0, 0, 0, 0, 1, 1, 100, 1);
    run_phase(300, 3, 1023, 511, 620, 460, 20, 20, 300, 2);
    c0 = $urandom_range(IMG_W - 16);
    r0 = $urandom_range(IMG_H - 16);
    run_phase(0, 1, 640, 480, c0, r0, 16, 16, 250, 3);
    run_phase(2000, 7, 37, 29, 0, 0, 37, 29, 300, 0);
    run_phase(100, 2, 640, 480, 300, 250, 12, 12, 300, 1);

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("depth_hole_fill_window_mean_core regression: pass");
    else
      $display("depth_hole_fill_window_mean_core regression: fail");
    $finish;
  end
endmodule
